// File: rtl/dnat_pkg.sv
// ----------------------------------------------------------------------------
// dnat_pkg
// Shared constants and types for the IPv4 destination NAT rewriter.
// ----------------------------------------------------------------------------
package dnat_pkg;

  localparam int HDR_MAX   = 60;               // largest header the buffer holds
  localparam int HDR_AW    = $clog2(HDR_MAX);  // header buffer address width
  localparam int QDEPTH    = 4;                // command queue depth
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [HDR_AW-1:0] HDR_MIN_LEN  = HDR_AW'(20);
  localparam logic [HDR_AW-1:0] HDR_MAX_LEN  = HDR_AW'(HDR_MAX);
  localparam logic [HDR_AW-1:0] PROTO_POS    = HDR_AW'(9);
  localparam logic [HDR_AW-1:0] CSUM_POS     = HDR_AW'(10);
  localparam logic [HDR_AW-1:0] ADDR_POS     = HDR_AW'(16);
  localparam logic [15:0]       PORT_OFS     = 16'd2;
  localparam logic [15:0]       TCP_CSUM_OFS = 16'd16;
  localparam logic [15:0]       POS_MAX      = 16'hFFFF;
  localparam logic [7:0]        PROTO_TCP    = 8'd6;

  localparam logic REG_DEST_ADDR = 1'b0;
  localparam logic REG_DEST_PORT = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,   // emit one byte
    KIND_PAIR = 2'd1,   // emit two bytes
    KIND_HDR  = 2'd2    // emit the buffered header
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t       kind;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [HDR_AW-1:0] len;     // header bytes present
    logic [15:0]       csum;    // header checksum to insert
    logic              last;
  } q_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_PAIR = 3'b010,
    BK_HDR  = 3'b100
  } back_state_t;

endpackage

// File: rtl/dnat_ram.sv
// ----------------------------------------------------------------------------
// dnat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dnat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dnat_fifo.sv
// ----------------------------------------------------------------------------
// dnat_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dnat_fifo import dnat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     enq,
  input  q_entry_t enq_data,
  output logic     full,
  input  logic     deq,
  output q_entry_t head,
  output logic     empty
);

  q_entry_t           slots [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QCW-1:0]     count;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/dnat_front.sv
// ----------------------------------------------------------------------------
// dnat_front
// Accepts packet bytes, buffers the header, keeps a running checksum and
// turns each byte into a queue command for the back part.
// ----------------------------------------------------------------------------
module dnat_front import dnat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              full,
  input  logic [31:0]       dest_addr,
  input  logic [15:0]       dest_port,
  input  logic              q_full,
  output logic              enq,
  output q_entry_t          enq_data,
  output logic              wr_en,
  output logic [HDR_AW-1:0] wr_addr,
  output logic [7:0]        wr_data,
  input  logic              hdr_done
);

  logic [15:0]       pos, pos_next;
  logic [HDR_AW-1:0] hl, hl_next;
  logic              tcp, tcp_next;
  logic              held_valid, held_valid_next;
  logic [7:0]        held_byte, held_byte_next;
  logic [15:0]       acc, acc_next;
  logic              busy, busy_next;

  logic [15:0]       hl16;
  logic              hdr_phase;
  logic              take;
  logic [HDR_AW-1:0] hp;
  logic [HDR_AW-1:0] len4;
  logic              len_ok;
  logic [HDR_AW-1:0] n;
  logic [7:0]        b_sub;
  logic [15:0]       word;
  logic [15:0]       base;
  logic [16:0]       s17;
  logic [15:0]       acc_sum;
  logic              rewrite;

  assign hl16      = 16'(hl);
  assign hdr_phase = (pos == '0) || (hl != '0 && pos < hl16);
  assign full      = q_full || (busy && hdr_phase);
  assign take      = push && !full;
  assign hp        = pos[HDR_AW-1:0];
  assign len4      = HDR_AW'({in_byte[3:0], 2'b00});
  assign len_ok    = (len4 >= HDR_MIN_LEN) && (len4 <= HDR_MAX_LEN);
  assign n         = hp + 1'b1;
  assign rewrite   = (hl != '0) && tcp && (dest_port != '0) && (pos != POS_MAX);

  // Byte as it counts toward the header checksum: the checksum field is
  // zero and the address field carries the new address.
  always_comb begin
    b_sub = in_byte;
    if (hp == CSUM_POS || hp == CSUM_POS + 1'b1) begin
      b_sub = '0;
    end else if (hp >= ADDR_POS && hp < ADDR_POS + HDR_AW'(4)) begin
      unique case (hp[1:0])
        2'd0: b_sub = dest_addr[31:24];
        2'd1: b_sub = dest_addr[23:16];
        2'd2: b_sub = dest_addr[15:8];
        2'd3: b_sub = dest_addr[7:0];
      endcase
    end
  end

  // Ones' complement accumulation with end-around carry.
  assign word    = hp[0] ? {8'h00, b_sub} : {b_sub, 8'h00};
  assign base    = (pos == '0) ? 16'h0000 : acc;
  assign s17     = {1'b0, base} + {1'b0, word};
  assign acc_sum = s17[15:0] + {15'b0, s17[16]};

  assign wr_addr = hp;
  assign wr_data = in_byte;

  always_comb begin
    pos_next        = pos;
    hl_next         = hl;
    tcp_next        = tcp;
    held_valid_next = held_valid;
    held_byte_next  = held_byte;
    acc_next        = acc;
    busy_next       = busy && !hdr_done;
    enq             = 1'b0;
    wr_en           = 1'b0;
    enq_data.kind   = KIND_BYTE;
    enq_data.b0     = in_byte;
    enq_data.b1     = in_byte;
    enq_data.len    = n;
    enq_data.csum   = ~acc_sum;
    enq_data.last   = in_last;

    if (take) begin
      if (pos == '0) begin
        wr_en    = 1'b1;
        acc_next = acc_sum;
        hl_next  = len_ok ? len4 : '0;
        enq      = !len_ok || in_last;
      end else if (hdr_phase) begin
        wr_en    = 1'b1;
        acc_next = acc_sum;
        if (hp == PROTO_POS) begin
          tcp_next = (in_byte == PROTO_TCP);
        end
        if (n == hl || in_last) begin
          enq           = 1'b1;
          enq_data.kind = KIND_HDR;
          busy_next     = 1'b1;
        end
      end else if (held_valid) begin
        enq             = 1'b1;
        enq_data.kind   = KIND_PAIR;
        held_valid_next = 1'b0;
        if (rewrite && pos == hl16 + PORT_OFS + 16'd1) begin
          enq_data.b0 = dest_port[15:8];
          enq_data.b1 = dest_port[7:0];
        end else if (rewrite && pos == hl16 + TCP_CSUM_OFS + 16'd1) begin
          enq_data.b0 = '0;
          enq_data.b1 = '0;
        end else begin
          enq_data.b0 = held_byte;
        end
      end else if (rewrite && !in_last &&
                   (pos == hl16 + PORT_OFS || pos == hl16 + TCP_CSUM_OFS)) begin
        held_valid_next = 1'b1;
        held_byte_next  = in_byte;
      end else begin
        enq = 1'b1;
      end

      if (in_last) begin
        pos_next        = '0;
        hl_next         = '0;
        tcp_next        = 1'b0;
        held_valid_next = 1'b0;
      end else if (pos != POS_MAX) begin
        pos_next = pos + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      hl         <= '0;
      tcp        <= 1'b0;
      held_valid <= 1'b0;
      busy       <= 1'b0;
    end else begin
      pos        <= pos_next;
      hl         <= hl_next;
      tcp        <= tcp_next;
      held_valid <= held_valid_next;
      busy       <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
    acc       <= acc_next;
  end

endmodule

// File: rtl/dnat_back.sv
// ----------------------------------------------------------------------------
// dnat_back
// Executes queue commands: emits single bytes, byte pairs and the buffered
// header with address and checksum inserted, through an output register.
// ----------------------------------------------------------------------------
module dnat_back import dnat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  q_entry_t          q_head,
  output logic              q_deq,
  output logic [HDR_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  input  logic [31:0]       dest_addr,
  output logic              hdr_done,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  back_state_t       state, state_next;
  logic              out_valid;
  logic [7:0]        pair_byte, pair_byte_next;
  logic              pair_last, pair_last_next;
  logic [HDR_AW-1:0] len, len_next;
  logic [15:0]       csum, csum_next;
  logic              rw, rw_next;
  logic              hdr_last, hdr_last_next;
  logic [HDR_AW-1:0] idx, idx_next;

  logic              can_load;
  logic              ld;
  logic [7:0]        ld_byte;
  logic              ld_last;
  logic              at_end;
  logic [7:0]        hdr_byte;

  assign empty    = !out_valid;
  assign can_load = !out_valid || pop;
  assign at_end   = (idx + 1'b1 == len);

  always_comb begin
    hdr_byte = rd_data;
    if (rw) begin
      if (idx == CSUM_POS) begin
        hdr_byte = csum[15:8];
      end else if (idx == CSUM_POS + 1'b1) begin
        hdr_byte = csum[7:0];
      end else if (idx >= ADDR_POS && idx < ADDR_POS + HDR_AW'(4)) begin
        unique case (idx[1:0])
          2'd0: hdr_byte = dest_addr[31:24];
          2'd1: hdr_byte = dest_addr[23:16];
          2'd2: hdr_byte = dest_addr[15:8];
          2'd3: hdr_byte = dest_addr[7:0];
        endcase
      end
    end
  end

  always_comb begin
    state_next     = state;
    pair_byte_next = pair_byte;
    pair_last_next = pair_last;
    len_next       = len;
    csum_next      = csum;
    rw_next        = rw;
    hdr_last_next  = hdr_last;
    idx_next       = idx;
    rd_addr        = idx;
    q_deq          = 1'b0;
    hdr_done       = 1'b0;
    ld             = 1'b0;
    ld_byte        = q_head.b0;
    ld_last        = q_head.last;

    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            KIND_BYTE: begin
              if (can_load) begin
                q_deq = 1'b1;
                ld    = 1'b1;
              end
            end
            KIND_PAIR: begin
              if (can_load) begin
                q_deq          = 1'b1;
                ld             = 1'b1;
                ld_last        = 1'b0;
                pair_byte_next = q_head.b1;
                pair_last_next = q_head.last;
                state_next     = BK_PAIR;
              end
            end
            KIND_HDR: begin
              q_deq         = 1'b1;
              len_next      = q_head.len;
              csum_next     = q_head.csum;
              rw_next       = (q_head.len >= HDR_MIN_LEN);
              hdr_last_next = q_head.last;
              idx_next      = '0;
              rd_addr       = '0;
              state_next    = BK_HDR;
            end
            default: begin
              q_deq = 1'b1;
            end
          endcase
        end
      end
      BK_PAIR: begin
        if (can_load) begin
          ld         = 1'b1;
          ld_byte    = pair_byte;
          ld_last    = pair_last;
          state_next = BK_IDLE;
        end
      end
      BK_HDR: begin
        if (can_load) begin
          ld      = 1'b1;
          ld_byte = hdr_byte;
          ld_last = hdr_last && at_end;
          if (at_end) begin
            hdr_done   = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pair_byte <= pair_byte_next;
    pair_last <= pair_last_next;
    len       <= len_next;
    csum      <= csum_next;
    rw        <= rw_next;
    hdr_last  <= hdr_last_next;
    idx       <= idx_next;
    if (ld) begin
      out_byte <= ld_byte;
      out_last <= ld_last;
    end
  end

endmodule

// File: rtl/ipv4_dest_nat_rewriter_unit.sv
// ----------------------------------------------------------------------------
// ipv4_dest_nat_rewriter_unit
// IPv4 destination NAT: new destination address, regenerated header
// checksum and optional TCP destination port rewrite.
// ----------------------------------------------------------------------------
// Usage. Packet bytes enter as words on the push/full queue port, one byte
// per word, with in_last set on the final byte. Rewritten bytes leave as
// words on the empty/pop port with out_last on the final byte. The two
// registers are written through cfg_write/cfg_index/cfg_data while the block
// is idle: index 0 is the new destination address, index 1 the TCP port
// (zero turns the port rewrite off).
// Flow. A payload byte passes through the command queue and then the
// output register before it can be popped. The header is held until its
// last byte arrives; it then passes the queue, the header buffer read and
// the output register, and drains at one byte per cycle while the receiver
// pops. Bytes are accepted at one per cycle while the queue has room;
// during a header drain the queue fills after four payload commands and
// input stalls until the drain ends. The first byte of the next packet
// waits until the previous header has left the header buffer.
// Reset (rst, synchronous) empties the queue and output register and clears
// both registers; the header buffer is not cleared. When the receiver stops
// popping, the output register holds its word, the four-entry command queue
// fills, and full rises.
// ----------------------------------------------------------------------------
module ipv4_dest_nat_rewriter_unit import dnat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]       dest_addr;
  logic [15:0]       dest_port;

  logic              q_full;
  logic              q_empty;
  logic              enq;
  logic              deq;
  q_entry_t          enq_data;
  q_entry_t          q_head;
  logic              wr_en;
  logic [HDR_AW-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [HDR_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              hdr_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_addr <= '0;
      dest_port <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEST_ADDR: dest_addr <= cfg_data;
        REG_DEST_PORT: dest_port <= cfg_data[15:0];
      endcase
    end
  end

  // The front takes bytes, stores the header and builds its checksum as the
  // bytes arrive, so the checksum is ready the moment the header closes.
  dnat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .full      (full),
    .dest_addr (dest_addr),
    .dest_port (dest_port),
    .q_full    (q_full),
    .enq       (enq),
    .enq_data  (enq_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .hdr_done  (hdr_done)
  );

  // Header buffer: written by the front, read by the back.
  dnat_ram #(
    .WIDTH (8),
    .DEPTH (HDR_MAX)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Command queue lets the front keep taking payload while the back waits
  // on the receiver or expands one command into several bytes.
  dnat_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_data (enq_data),
    .full     (q_full),
    .deq      (deq),
    .head     (q_head),
    .empty    (q_empty)
  );

  dnat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_deq     (deq),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .dest_addr (dest_addr),
    .hdr_done  (hdr_done),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: rtl/dnat_checker.sv
// ----------------------------------------------------------------------------
// dnat_checker
// Port-level checks for the IPv4 destination NAT rewriter.
// ----------------------------------------------------------------------------
module dnat_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // Reset leaves room for input.
  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // A word must cross the queue and the output register, so none is out right after reset.
  a_min_latency: assert property (@(posedge clk) $past(rst) |=> empty)
    else $error("output word appeared too early after reset");

  // A waiting word holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("output word changed while stalled");

endmodule

bind ipv4_dest_nat_rewriter_unit dnat_checker u_dnat_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .out_last (out_last)
);

// File: tb/tb_ipv4_dest_nat_rewriter_unit.sv
// ----------------------------------------------------------------------------
// tb_ipv4_dest_nat_rewriter_unit
// Self-checking testbench for the IPv4 destination NAT rewriter.
//
// Packets are pushed one byte per word. A behavioral model inside this module
// predicts every output word, including the rewritten address, the header
// checksum and the TCP port rewrite. A separate receiver process pops words
// with random stalls and compares each one with the oldest prediction.
// Directed packets cover the corner cases, one test at a time.
// ----------------------------------------------------------------------------
module tb_ipv4_dest_nat_rewriter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dnat_pkg::*;

  // One output word: a packet byte and its end-of-packet flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } nat_word_t;

  // All block inputs start at known values.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  in_byte   = 8'h00;
  logic        in_last   = 1'b0;
  logic        empty;
  logic        pop       = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_DEST_ADDR;
  logic [31:0] cfg_data  = 32'h0;

  ipv4_dest_nat_rewriter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the rewriter. It keeps its own header buffer, packet
  // position and register values, and turns every accepted input byte into
  // the list of words the block must produce for it.
  // --------------------------------------------------------------------------
  logic [7:0]  hdr_copy [HDR_MAX];
  int unsigned pkt_pos;
  int unsigned hdr_len;          // zero means the packet passes untouched
  bit          tcp_pkt;
  bit          pair_held;        // first byte of a port or checksum pair waits
  logic [7:0]  pair_first;
  logic [31:0] nat_addr;
  logic [15:0] nat_port;

  nat_word_t   step_out[$];      // words caused by the current byte
  nat_word_t   pending_out[$];   // words predicted but not yet popped

  // Knobs shared between the stimulus and the receiver process.
  int send_gap_max = 10;
  int take_gap_max = 10;
  int hold_cycles  = 0;

  // Run statistics.
  int mismatches   = 0;
  int packets_sent = 0;
  int bytes_in     = 0;
  int words_out    = 0;

  function automatic void reset_model();
    pkt_pos    = 0;
    hdr_len    = 0;
    tcp_pkt    = 1'b0;
    pair_held  = 1'b0;
    pair_first = 8'h00;
    nat_addr   = 32'h0;
    nat_port   = 16'h0;
    pending_out.delete();
  endfunction

  function automatic void put_byte(logic [7:0] b);
    nat_word_t w;
    w.data = b;
    w.last = 1'b0;
    step_out.push_back(w);
  endfunction

  // Release the first n buffered header bytes. Once twenty bytes are present
  // the address is replaced and the checksum regenerated; header bytes that
  // never arrived count as zero in the sum.
  function automatic void emit_header(int unsigned n);
    int unsigned i;
    logic [31:0] sum;
    logic [7:0]  hi, lo;
    if (n >= HDR_MIN_LEN) begin
      hdr_copy[int'(ADDR_POS)]     = nat_addr[31:24];
      hdr_copy[int'(ADDR_POS) + 1] = nat_addr[23:16];
      hdr_copy[int'(ADDR_POS) + 2] = nat_addr[15:8];
      hdr_copy[int'(ADDR_POS) + 3] = nat_addr[7:0];
      hdr_copy[int'(CSUM_POS)]     = 8'h00;
      hdr_copy[int'(CSUM_POS) + 1] = 8'h00;
      sum = 32'h0;
      for (i = 0; i + 1 < hdr_len && i + 1 < HDR_MAX; i += 2) begin
        hi  = (i < n)     ? hdr_copy[i]     : 8'h00;
        lo  = (i + 1 < n) ? hdr_copy[i + 1] : 8'h00;
        sum = sum + {16'h0, hi, lo};
      end
      sum = {16'h0, sum[15:0]} + (sum >> 16);
      sum = {16'h0, sum[15:0]} + (sum >> 16);
      sum = ~sum;
      hdr_copy[int'(CSUM_POS)]     = sum[15:8];
      hdr_copy[int'(CSUM_POS) + 1] = sum[7:0];
      tcp_pkt = (hdr_copy[int'(PROTO_POS)] == PROTO_TCP);
    end
    for (i = 0; i < n && i < HDR_MAX; i++)
      put_byte(hdr_copy[i]);
  endfunction

  // Advance the model by one accepted byte and queue the words it causes.
  function automatic void rewrite_byte(logic [7:0] b, logic last);
    int unsigned pos, hl, len4;
    bit          rewrite;
    pos = pkt_pos;
    hl  = hdr_len;
    step_out.delete();
    if (pos == 0) begin
      len4        = 4 * int'(b[3:0]);
      hdr_copy[0] = b;
      if (len4 < HDR_MIN_LEN || len4 > HDR_MAX) begin
        // IHL below five: the whole packet goes straight through.
        hdr_len = 0;
        put_byte(b);
      end else begin
        hdr_len = len4;
        if (last)
          emit_header(1);
      end
    end else if (hl != 0 && pos < hl) begin
      hdr_copy[pos] = b;
      if (pos + 1 == hl || last)
        emit_header(pos + 1);
    end else begin
      rewrite = hl != 0 && tcp_pkt && nat_port != 16'h0 && pos < POS_MAX;
      if (pair_held) begin
        if (rewrite && pos == hl + PORT_OFS + 1) begin
          put_byte(nat_port[15:8]);
          put_byte(nat_port[7:0]);
        end else if (rewrite && pos == hl + TCP_CSUM_OFS + 1) begin
          put_byte(8'h00);
          put_byte(8'h00);
        end else begin
          put_byte(pair_first);
          put_byte(b);
        end
        pair_held = 1'b0;
      end else if (rewrite && !last &&
                   (pos == hl + PORT_OFS || pos == hl + TCP_CSUM_OFS)) begin
        pair_first = b;
        pair_held  = 1'b1;
      end else begin
        put_byte(b);
      end
    end

    if (last) begin
      if (step_out.size() > 0)
        step_out[step_out.size() - 1].last = 1'b1;
      pkt_pos   = 0;
      hdr_len   = 0;
      tcp_pkt   = 1'b0;
      pair_held = 1'b0;
    end else if (pos < POS_MAX) begin
      pkt_pos = pos + 1;
    end
    foreach (step_out[k])
      pending_out.push_back(step_out[k]);
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line per mismatch, and a running count.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Input side. The caller is always just past a rising edge. A random gap
  // lowers push first; with no gap push simply stays high for the next word.
  // The word is taken at the first edge where full is low, and only then
  // does the model see it.
  // --------------------------------------------------------------------------
  task automatic send_word(logic [7:0] b, logic last);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (full);
    rewrite_byte(b, last);
    bytes_in++;
  endtask

  // Build and send one packet. A negative fill gives random content;
  // otherwise every byte takes the fill value apart from the IHL nibble and
  // the protocol byte.
  task automatic send_packet(int ihl, logic [7:0] proto, int len, int fill);
    logic [7:0] pkt[$];
    logic [3:0] ver;
    int         i;
    for (i = 0; i < len; i++)
      pkt.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    ver    = (fill < 0) ? 4'($urandom) : 4'(fill >> 4);
    pkt[0] = {ver, 4'(ihl)};
    if (len > 9)
      pkt[9] = proto;
    for (i = 0; i < len; i++)
      send_word(pkt[i], i == len - 1);
    packets_sent++;
  endtask

  // Stop offering words and wait until every predicted word has been popped,
  // plus a wait for anything still moving through the pipeline.
  task automatic settle();
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Registers are only written while the block is idle. Both are written on
  // every change, on back-to-back cycles, so that cfg_write is raised once
  // and lowered once.
  task automatic program_nat(logic [31:0] addr, logic [15:0] port);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_DEST_ADDR;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= REG_DEST_PORT;
    cfg_data  <= {16'h0, port};
    @(posedge clk);
    cfg_write <= 1'b0;
    nat_addr = addr;
    nat_port = port;
  endtask

  // --------------------------------------------------------------------------
  // Output side. The receiver draws a pause before every word, and a test can
  // ask it to hold off for a long stretch. Each popped word is compared with
  // the oldest prediction, field by field.
  // --------------------------------------------------------------------------
  initial begin
    nat_word_t want;
    int        gap;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = $urandom_range(0, take_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h last %0b", out_byte, out_last));
      end else begin
        want = pending_out.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("word %0d: out_byte %02h, expected %02h",
                                    words_out, out_byte, want.data));
        if (out_last !== want.last)
          report_mismatch($sformatf("word %0d: out_last %0b, expected %0b",
                                    words_out, out_last, want.last));
      end
      words_out++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Packets that leave the block untouched: IHL below five (also as a single
  // byte), a one-byte packet with a valid IHL, and a packet that ends before
  // the twenty-byte minimum header.
  task automatic test_pass_through();
    program_nat(32'h0A00_0001, 16'h0050);
    send_packet(0, PROTO_TCP, 1, 0);
    send_packet(4, PROTO_TCP, 6, -1);
    send_packet(5, PROTO_TCP, 1, -1);
    send_packet(6, 8'd17, 12, -1);
  endtask

  // Full headers with all-zero and all-one content and a zero address, with
  // the port rewrite switched off.
  task automatic test_header_rewrite();
    program_nat(32'h0000_0000, 16'h0000);
    send_packet(5, PROTO_TCP, 20, 0);
    send_packet(6, 8'hFF, 24, 8'hFF);
  endtask

  // TCP port and checksum rewrite with all-one registers: first the port
  // pair cut short by the end of the packet, then a rewritten port with the
  // TCP checksum pair cut short.
  task automatic test_tcp_port();
    program_nat(32'hFFFF_FFFF, 16'hFFFF);
    send_packet(5, PROTO_TCP, 20 + 3, -1);
    send_packet(5, PROTO_TCP, 20 + 17, -1);
  endtask

  // Header claims more bytes than the packet holds: the checksum counts the
  // missing bytes as zero and only the bytes present come out.
  task automatic test_truncated_header();
    program_nat(32'h7F00_0001, 16'h0016);
    send_packet(15, PROTO_TCP, 22, -1);
  endtask

  // The receiver holds off for a long stretch while the sender pushes
  // without gaps, so the command queue fills and full must rise. The packet
  // reaches both the port and the TCP checksum pairs.
  task automatic test_backpressure();
    program_nat(32'h0A0B_0C0D, 16'h0BB8);
    send_gap_max = 0;
    hold_cycles  = 300;
    send_packet(5, PROTO_TCP, 38, -1);
    send_gap_max = 10;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: one reset, the tests in turn, then drain and verdict.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    reset_model();

    test_pass_through();
    test_header_rewrite();
    test_tcp_port();
    test_truncated_header();
    test_backpressure();

    settle();
    $display("Sent %0d packets (%0d bytes) and checked %0d output words.",
             packets_sent, bytes_in, words_out);
    $display("Covered pass-through, short and truncated headers, TCP port and");
    $display("checksum pairs, and a long receiver stall with the input held off.");
    if (mismatches == 0) begin
      $display("** ipv4_dest_nat_rewriter_unit: PASSED **");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("** ipv4_dest_nat_rewriter_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #500_000;
    $display("Timeout with %0d words still expected.", pending_out.size());
    $display("** ipv4_dest_nat_rewriter_unit: FAILED **");
    $finish;
  end

endmodule
